// ===== rtl/core/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and zone helpers for the steering pulse sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Default saturation limit of the pulse counter
  localparam int MAX_COUNT_DEF = 255;

  // Field widths
  localparam int XW      = 16;
  localparam int BANDW   = 15;
  localparam int DUTYW   = 8;
  localparam int TICKSW  = 21;
  localparam int DIRW    = 2;
  localparam int ZONEW   = 4;
  localparam int REMW    = 8;
  localparam int CMDW    = 32;
  localparam int CFG_IDXW  = 2;
  localparam int CFG_DATAW = 21;

  // Zone thresholds in Q2.14
  localparam logic signed [XW-1:0] Q_0_125 = 16'sd2048;
  localparam logic signed [XW-1:0] Q_0_25  = 16'sd4096;
  localparam logic signed [XW-1:0] Q_0_375 = 16'sd6144;
  localparam logic signed [XW-1:0] Q_0_625 = 16'sd10240;
  localparam logic signed [XW-1:0] Q_0_75  = 16'sd12288;
  localparam logic signed [XW-1:0] Q_0_875 = 16'sd14336;
  localparam logic signed [XW-1:0] Q_1_0   = 16'sd16384;

  // Register reset values
  localparam logic [BANDW-1:0]  BAND_LOW_RST    = 15'd8110;
  localparam logic [BANDW-1:0]  BAND_HIGH_RST   = 15'd8274;
  localparam logic [DUTYW-1:0]  DUTY_VALUE_RST  = 8'd80;
  localparam logic [TICKSW-1:0] PULSE_TICKS_RST = 21'd78125;

  // Direction codes
  localparam logic [DIRW-1:0] DIR_NONE  = 2'd0;
  localparam logic [DIRW-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIRW-1:0] DIR_LEFT  = 2'd2;

  localparam logic signed [ZONEW-1:0] ZONE_CENTER = 4'sd0;

  typedef enum logic [CFG_IDXW-1:0] {
    REG_BAND_LOW    = 2'd0,
    REG_BAND_HIGH   = 2'd1,
    REG_DUTY_VALUE  = 2'd2,
    REG_PULSE_TICKS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [BANDW-1:0]  band_low;
    logic [BANDW-1:0]  band_high;
    logic [DUTYW-1:0]  duty_value;
    logic [TICKSW-1:0] pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CMDW-1:0]         command_word;
    logic [DIRW-1:0]         direction;
    logic signed [ZONEW-1:0] zone;
    logic [REMW-1:0]         remaining;
    logic                    returning;
  } result_t;

  // Sort a sample into zones -4..4; band check first, band used as written
  function automatic logic signed [ZONEW-1:0] classify(
    input logic signed [XW-1:0] x,
    input logic [BANDW-1:0]     lo,
    input logic [BANDW-1:0]     hi
  );
    logic signed [XW-1:0] slo;
    logic signed [XW-1:0] shi;
    logic signed [ZONEW-1:0] z;
    slo = $signed({1'b0, lo});
    shi = $signed({1'b0, hi});
    if (x >= slo && x <= shi) z = 4'sd0;
    else if (x < Q_0_125)     z = -4'sd4;
    else if (x < Q_0_25)      z = -4'sd3;
    else if (x < Q_0_375)     z = -4'sd2;
    else if (x < slo)         z = -4'sd1;
    else if (x <= Q_0_625)    z = 4'sd1;
    else if (x <= Q_0_75)     z = 4'sd2;
    else if (x <= Q_0_875)    z = 4'sd3;
    else if (x <= Q_1_0)      z = 4'sd4;
    else                      z = 4'sd0;
    return z;
  endfunction

  // Magnitude of a zone (range 0..4)
  function automatic logic [2:0] zone_mag(input logic signed [ZONEW-1:0] z);
    logic [ZONEW-1:0] n;
    n = -z;
    return z[ZONEW-1] ? n[2:0] : z[2:0];
  endfunction

endpackage

// ===== rtl/core/sps_ifs.sv =====
// ----------------------------------------------------------------------------
// sps channel interfaces
// Valid/ready channels for position samples and motor command items.
// ----------------------------------------------------------------------------
interface sps_in_if
  import sps_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] x_pos;

  modport source (output valid, output x_pos, input ready);
  modport sink   (input valid, input x_pos, output ready);
endinterface

interface sps_out_if
  import sps_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CMDW-1:0]         command_word;
  logic [DIRW-1:0]         direction;
  logic signed [ZONEW-1:0] zone;
  logic [REMW-1:0]         remaining;
  logic                    returning;

  modport source (output valid, output command_word, output direction, output zone,
                  output remaining, output returning, input ready);
  modport sink   (input valid, input command_word, input direction, input zone,
                  input remaining, input returning, output ready);
endinterface

// ===== rtl/core/sps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sps_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module sps_cfg_regs
  import sps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDXW-1:0]  cfg_index,
  input  logic [CFG_DATAW-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_idx_t idx;
  assign idx = cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_low    <= BAND_LOW_RST;
      cfg.band_high   <= BAND_HIGH_RST;
      cfg.duty_value  <= DUTY_VALUE_RST;
      cfg.pulse_ticks <= PULSE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (idx)
        REG_BAND_LOW:    cfg.band_low    <= cfg_wdata[BANDW-1:0];
        REG_BAND_HIGH:   cfg.band_high   <= cfg_wdata[BANDW-1:0];
        REG_DUTY_VALUE:  cfg.duty_value  <= cfg_wdata[DUTYW-1:0];
        REG_PULSE_TICKS: cfg.pulse_ticks <= cfg_wdata[TICKSW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/sps_step.sv =====
// ----------------------------------------------------------------------------
// sps_step
// Zone sort, pulse decision and sequencer state for one sample per cycle while advance is high.
// ----------------------------------------------------------------------------
module sps_step
  import sps_pkg::*;
#(
  parameter int MaxCount = MAX_COUNT_DEF,
  parameter int CountW   = $clog2(MaxCount + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,  // sample in the input register is consumed
  input  logic signed [XW-1:0] x_pos,
  input  cfg_t                 cfg,
  output logic                 fire,
  output result_t              result
);

  logic [CountW-1:0]       pulse_count, pulse_count_next;
  logic                    return_flag, return_flag_next;
  logic [DIRW-1:0]         last_direction, last_direction_next;
  logic signed [ZONEW-1:0] previous_zone, previous_zone_next;

  logic signed [ZONEW-1:0] zone;
  logic [2:0]              zmag, pmag;
  logic [DIRW-1:0]         dir;

  assign zone = classify(x_pos, cfg.band_low, cfg.band_high);
  assign zmag = zone_mag(zone);
  assign pmag = zone_mag(previous_zone);

  always_comb begin
    pulse_count_next    = pulse_count;
    return_flag_next    = return_flag;
    last_direction_next = last_direction;
    previous_zone_next  = previous_zone;
    dir                 = DIR_NONE;
    fire                = 1'b0;
    if (!return_flag) begin
      if (zone != ZONE_CENTER && zmag > pmag) begin
        // outward step: steer toward the sample's side
        dir  = zone[ZONEW-1] ? DIR_LEFT : DIR_RIGHT;
        fire = 1'b1;
        if (pulse_count < CountW'(MaxCount)) pulse_count_next = pulse_count + 1'b1;
        last_direction_next = dir;
        previous_zone_next  = zone;
      end else if (zone == ZONE_CENTER && pulse_count != '0) begin
        return_flag_next = 1'b1;
      end else if (zone != ZONE_CENTER && zmag < pmag) begin
        previous_zone_next = zone;
      end
    end else begin
      // unwind: opposite of the last steering pulse
      if (last_direction == DIR_RIGHT)     dir = DIR_LEFT;
      else if (last_direction == DIR_LEFT) dir = DIR_RIGHT;
      else                                 dir = DIR_NONE;
      if (pulse_count != '0 && dir != DIR_NONE) begin
        fire             = 1'b1;
        pulse_count_next = pulse_count - 1'b1;
      end else begin
        return_flag_next   = 1'b0;
        previous_zone_next = ZONE_CENTER;
      end
    end
  end

  always_comb begin
    result.command_word = {1'b1, dir, cfg.duty_value, cfg.pulse_ticks};
    result.direction    = dir;
    result.zone         = zone;
    result.remaining    = REMW'(pulse_count_next);
    result.returning    = return_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count    <= '0;
      return_flag    <= 1'b0;
      last_direction <= DIR_NONE;
      previous_zone  <= ZONE_CENTER;
    end else if (advance) begin
      pulse_count    <= pulse_count_next;
      return_flag    <= return_flag_next;
      last_direction <= last_direction_next;
      previous_zone  <= previous_zone_next;
    end
  end

endmodule

// ===== rtl/core/steer_pulse_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// steer_pulse_sequencer_top
// Steering pulse sequencer: position samples in, motor command items out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one signed Q2.14 x_pos sample per item (valid/ready).
//   out_ch carries one motor command item per emitted pulse: command_word,
//          direction, zone, remaining and returning. Samples that emit no
//          pulse produce no output item.
//   cfg_we/cfg_index/cfg_wdata write band_low, band_high, duty_value and
//   pulse_ticks; write only while the block is idle.
// Path: an accepted sample is held in the input register; when it leaves
//   that register, which waits while out_ch stalls, its command item, if
//   any, is written into the result register that drives out_ch. The
//   sequencer state is updated when a sample leaves the input register.
// Throughput: one item per cycle while out_ch does not stall, set by the
//   state update between the input register and the result register.
// Reset (rst, synchronous): both pipeline registers empty, pulse count,
//   return mode, last direction and remembered zone cleared, registers back
//   to their defaults.
// Stall: while out_ch holds an item that is not taken, every sample waits in
//   the input register, pulse or not; samples keep flowing as long as the
//   output register is free or being drained.
// ----------------------------------------------------------------------------
module steer_pulse_sequencer_top
  import sps_pkg::*;
#(
  parameter int MaxCount = MAX_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDXW-1:0]  cfg_index,
  input  logic [CFG_DATAW-1:0] cfg_wdata,
  sps_in_if.sink               in_ch,
  sps_out_if.source            out_ch
);

  localparam int CountW = $clog2(MaxCount + 1);

  cfg_t cfg;

  // input register
  logic                 s1_valid;
  logic signed [XW-1:0] s1_x;

  // result register
  logic    o_valid;
  result_t o_data;

  logic    advance;
  logic    fire;
  result_t result;

  sps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sps_step #(
    .MaxCount (MaxCount),
    .CountW   (CountW)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .x_pos   (s1_x),
    .cfg     (cfg),
    .fire    (fire),
    .result  (result)
  );

  // A sample moves on when the result register is free or draining this cycle.
  assign advance     = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_x <= in_ch.x_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance && fire) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      o_data <= result;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.command_word = o_data.command_word;
  assign out_ch.direction    = o_data.direction;
  assign out_ch.zone         = o_data.zone;
  assign out_ch.remaining    = o_data.remaining;
  assign out_ch.returning    = o_data.returning;

endmodule

// ===== rtl/core/sps_checker.sv =====
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks on command items, bound to the top level.
// ----------------------------------------------------------------------------
module sps_checker
  import sps_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CMDW-1:0]         command_word,
  input logic [DIRW-1:0]         direction,
  input logic signed [ZONEW-1:0] zone,
  input logic                    returning
);

  // held item's command word stays put while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command_word))
    else $error("output item changed while stalled");

  // direction field in the word matches the direction output, and the top bit is set
  a_dir_field: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> command_word[31] && command_word[30:29] == direction)
    else $error("command word header does not match direction");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> direction == DIR_RIGHT || direction == DIR_LEFT)
    else $error("pulse with no direction");

  // a steering pulse outside return mode always points at the sample's side
  a_steer_side: assert property (@(posedge clk) disable iff (rst)
    out_valid && !returning |->
      (zone[ZONEW-1] && direction == DIR_LEFT) ||
      (!zone[ZONEW-1] && zone != ZONE_CENTER && direction == DIR_RIGHT))
    else $error("steering pulse toward the wrong side");

endmodule

bind steer_pulse_sequencer_top sps_checker u_sps_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .command_word (out_ch.command_word),
  .direction    (out_ch.direction),
  .zone         (out_ch.zone),
  .returning    (out_ch.returning)
);
